// ===== rtl/bba_pkg.sv =====
// Types and constants shared by the buddy allocator modules.
package bba_pkg;

  localparam int unsigned POOL_CHUNKS    = 16;
  localparam int unsigned GRAN_PER_CHUNK = 128;
  localparam int unsigned GRANULES       = POOL_CHUNKS * GRAN_PER_CHUNK;
  localparam int unsigned GA_W           = $clog2(GRANULES);
  localparam int unsigned GC_W           = $clog2(GRAN_PER_CHUNK);
  localparam int unsigned ENTRY_W        = 5;
  localparam int unsigned LVL_W          = 3;
  localparam logic [LVL_W-1:0] TOP_LEVEL = 3'd7;
  localparam logic [12:0] CHUNK_BYTES_C  = 13'd2048;

  localparam logic [6:0] HDR_RESET   = 7'd16;
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    CFG_HEADER = 2'd0,
    CFG_LIMIT  = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_BAD_SIZE = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic        command;
    logic [11:0] request_bytes;
    logic [14:0] user_address;
  } in_req_t;

  typedef struct packed {
    logic [14:0] granted_address;
    logic [1:0]  status;
  } out_res_t;

  typedef struct packed {
    logic             start;
    logic             used;
    logic [LVL_W-1:0] level;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [GA_W-1:0]    waddr;
    entry_t             wdata;
    logic [GA_W-1:0]    raddr;
  } mem_cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SRD,
    S_SCHK,
    S_DECIDE,
    S_SPLIT,
    S_FRD,
    S_FCHK,
    S_MTEST,
    S_MCHK,
    S_WAIT
  } state_t;

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Buddy allocator top level: request sequencer around the granule table.
// Alloc: scans block positions at the stride of the requested level (up to
// 2048 positions), then splits the chosen block down to that level. Free: reads
// and checks the entry, then merges with free buddies. One request at a time.
// Reset: synchronous; a clearing pass writes all 2048 granule entries
// before the first request is taken.
module buddy_block_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bba_pkg::out_res_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_wdata
);
  import bba_pkg::*;

  state_t            state_r, state_nxt;
  logic [GA_W-1:0]   g_r, g_nxt;
  logic [GA_W-1:0]   bud_r, bud_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic [LVL_W-1:0]  k_r, k_nxt;
  logic [7:0]        found_r, found_nxt;
  logic [GA_W-1:0]   fpos_r [8];
  logic [GA_W-1:0]   fpos_nxt [8];
  logic [4:0]        claimed_r, claimed_nxt;
  logic [6:0]        hdr_r;
  logic [4:0]        lim_r;
  out_res_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;

  mem_cmd_t mcmd;
  entry_t   rd_e;

  bba_mem u_mem (
    .clk     (clk),
    .cmd     (mcmd),
    .rd_data (rd_e)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [GA_W:0]  scan_end;
  logic [12:0]    total;
  logic [LVL_W-1:0] need_lv;
  logic [15:0]    fbase;
  logic [GA_W:0]  g_step;
  logic [LVL_W-1:0] pick;
  logic [4:0]     eff_lim;
  logic [GA_W-1:0] bud_c;
  logic [15:0]    gaddr;

  assign scan_end = {claimed_r, {GC_W{1'b0}}};
  assign total    = 13'(hdr_r) + 13'(in_data.request_bytes);
  assign fbase    = {1'b0, in_data.user_address} - 16'(hdr_r);
  assign g_step   = {1'b0, g_r} + ((GA_W+1)'(1) << lv_r);
  assign eff_lim  = (lim_r > 5'(POOL_CHUNKS)) ? 5'(POOL_CHUNKS) : lim_r;
  assign bud_c    = g_r ^ (GA_W'(1) << k_r);
  assign gaddr    = 16'({g_r, 4'b0000}) + 16'(hdr_r);

  always_comb begin
    need_lv = TOP_LEVEL;
    for (int i = 6; i >= 0; i--) begin
      if ((13'd16 << i) >= total) need_lv = LVL_W'(i);
    end
    pick = TOP_LEVEL;
    for (int i = 7; i >= 0; i--) begin
      if (found_r[i]) pick = LVL_W'(i);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    g_nxt         = g_r;
    bud_nxt       = bud_r;
    lv_nxt        = lv_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    fpos_nxt      = fpos_r;
    claimed_nxt   = claimed_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mcmd          = '0;
    mcmd.raddr    = g_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mcmd.we    = 1'b1;
        mcmd.waddr = g_r;
        g_nxt      = g_r + 1'b1;
        if (g_r == GA_W'(GRANULES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          found_nxt = '0;
          if (in_data.command == CMD_ALLOC) begin
            if (in_data.request_bytes == 12'd0 || total > CHUNK_BYTES_C) begin
              res_nxt.status = ST_BAD_SIZE;
              state_nxt      = S_WAIT;
            end else begin
              lv_nxt    = need_lv;
              g_nxt     = '0;
              state_nxt = (claimed_r == 5'd0) ? S_DECIDE : S_SRD;
            end
          end else begin
            if (in_data.user_address < 15'(hdr_r) || fbase[3:0] != 4'd0 ||
                fbase[14:4] >= scan_end[GA_W-1:0] && scan_end[GA_W] == 1'b0 ||
                fbase[15] == 1'b1) begin
              res_nxt.status = ST_BAD_FREE;
              state_nxt      = S_WAIT;
            end else begin
              g_nxt     = fbase[14:4];
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_SRD: begin
        mcmd.raddr = g_r;
        state_nxt  = S_SCHK;
      end
      S_SCHK: begin
        state_nxt = S_SRD;
        if (rd_e.start && !rd_e.used && rd_e.level >= lv_r && !found_r[rd_e.level]) begin
          found_nxt[rd_e.level] = 1'b1;
          fpos_nxt[rd_e.level]  = g_r;
        end
        if ((rd_e.start && !rd_e.used && rd_e.level == lv_r) || g_step >= scan_end) begin
          state_nxt = S_DECIDE;
        end else begin
          g_nxt = g_step[GA_W-1:0];
        end
      end
      S_DECIDE: begin
        if (|found_r) begin
          g_nxt     = fpos_r[pick];
          k_nxt     = pick;
          state_nxt = S_SPLIT;
        end else if (claimed_r >= eff_lim) begin
          res_nxt.status = ST_NOMEM;
          state_nxt      = S_WAIT;
        end else begin
          g_nxt       = GA_W'({claimed_r, {GC_W{1'b0}}});
          claimed_nxt = claimed_r + 1'b1;
          k_nxt       = TOP_LEVEL;
          state_nxt   = S_SPLIT;
        end
      end
      S_SPLIT: begin
        mcmd.we = 1'b1;
        if (k_r > lv_r) begin
          mcmd.waddr = g_r + (GA_W'(1) << (k_r - 1'b1));
          mcmd.wdata = '{start: 1'b1, used: 1'b0, level: k_r - 1'b1};
          k_nxt      = k_r - 1'b1;
        end else begin
          mcmd.waddr = g_r;
          mcmd.wdata = '{start: 1'b1, used: 1'b1, level: lv_r};
          res_nxt.granted_address = gaddr[14:0];
          res_nxt.status          = ST_OK;
          state_nxt               = S_WAIT;
        end
      end
      S_FRD: begin
        mcmd.raddr = g_r;
        state_nxt  = S_FCHK;
      end
      S_FCHK: begin
        if (!rd_e.start || !rd_e.used) begin
          res_nxt.status = ST_BAD_FREE;
          state_nxt      = S_WAIT;
        end else begin
          k_nxt     = rd_e.level;
          state_nxt = S_MTEST;
        end
      end
      S_MTEST: begin
        if (k_r == TOP_LEVEL) begin
          mcmd.we    = 1'b1;
          mcmd.waddr = g_r;
          mcmd.wdata = '{start: 1'b1, used: 1'b0, level: k_r};
          res_nxt.status = ST_OK;
          state_nxt      = S_WAIT;
        end else begin
          mcmd.raddr = bud_c;
          bud_nxt    = bud_c;
          state_nxt  = S_MCHK;
        end
      end
      S_MCHK: begin
        mcmd.we = 1'b1;
        if (rd_e.start && !rd_e.used && rd_e.level == k_r) begin
          mcmd.wdata = '0;
          if (bud_r < g_r) begin
            mcmd.waddr = g_r;
            g_nxt      = bud_r;
          end else begin
            mcmd.waddr = bud_r;
          end
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MTEST;
        end else begin
          mcmd.waddr     = g_r;
          mcmd.wdata     = '{start: 1'b1, used: 1'b0, level: k_r};
          res_nxt.status = ST_OK;
          state_nxt      = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      g_r         <= '0;
      claimed_r   <= '0;
      hdr_r       <= HDR_RESET;
      lim_r       <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      found_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      g_r         <= g_nxt;
      claimed_r   <= claimed_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      if (cfg_we && cfg_index == CFG_HEADER) hdr_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_LIMIT)  lim_r <= cfg_wdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    bud_r      <= bud_nxt;
    lv_r       <= lv_nxt;
    k_r        <= k_nxt;
    fpos_r     <= fpos_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/bba_mem.sv =====
// Granule table memory: one write port, one read port, registered read data.
module bba_mem (
  input  logic              clk,
  input  bba_pkg::mem_cmd_t cmd,
  output bba_pkg::entry_t   rd_data
);
  import bba_pkg::*;

  entry_t mem [GRANULES];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rd_data <= mem[cmd.raddr];
  end

endmodule

// ===== test/bba_checker.sv =====
// Buddy allocator checker: tracks pool state, predicts each result and compares it.
`timescale 1ns / 100ps
module bba_checker
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_req_t   in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_res_t  out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  output int        fails,
  output int        pending
);

  entry_t   pool_map [0:GRANULES-1];
  int       chunks_used;
  logic [6:0] hdr_bytes;
  logic [4:0] chunk_cap;
  out_res_t expected_q[$];

  assign pending = expected_q.size();

  function automatic int lowest_free(int lv);
    for (int g = 0; g < chunks_used * GRAN_PER_CHUNK; g += (1 << lv)) begin
      if (pool_map[g].start && !pool_map[g].used && pool_map[g].level == lv) return g;
    end
    return -1;
  endfunction

  function automatic out_res_t predict_alloc(int req);
    out_res_t r;
    int total, lv, h, g, cap;
    r = '0;
    total = int'(hdr_bytes) + req;
    if (req == 0 || total > 2048) begin
      r.status = ST_BAD_SIZE;
      return r;
    end
    lv = 0;
    while (lv < 7 && (16 << lv) < total) lv++;
    g = -1;
    for (h = lv; h <= 7; h++) begin
      g = lowest_free(h);
      if (g >= 0) break;
    end
    if (g < 0) begin
      cap = (chunk_cap > POOL_CHUNKS) ? POOL_CHUNKS : int'(chunk_cap);
      if (chunks_used >= cap) begin
        r.status = ST_NOMEM;
        return r;
      end
      g = chunks_used * GRAN_PER_CHUNK;
      chunks_used++;
      h = 7;
    end
    // keep the lower half at each split, upper halves become free blocks
    for (int k = h - 1; k >= lv; k--) pool_map[g + (1 << k)] = '{1'b1, 1'b0, 3'(k)};
    pool_map[g] = '{1'b1, 1'b1, 3'(lv)};
    r.granted_address = 15'((g * 16 + int'(hdr_bytes)) & 'h7FFF);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic out_res_t predict_free(int addr);
    out_res_t r;
    int base, g, lv, b;
    r = '0;
    r.status = ST_BAD_FREE;
    if (addr < int'(hdr_bytes)) return r;
    base = addr - int'(hdr_bytes);
    if (base % 16 != 0) return r;
    g = base / 16;
    if (g >= chunks_used * GRAN_PER_CHUNK) return r;
    if (!pool_map[g].start || !pool_map[g].used) return r;
    lv = pool_map[g].level;
    while (lv < 7) begin
      b = g ^ (1 << lv);
      if (!pool_map[b].start || pool_map[b].used || pool_map[b].level != lv) break;
      if (b < g) begin
        pool_map[g] = '0;
        g = b;
      end else begin
        pool_map[b] = '0;
      end
      lv++;
    end
    pool_map[g] = '{1'b1, 1'b0, 3'(lv)};
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      foreach (pool_map[i]) pool_map[i] = '0;
      chunks_used = 0;
      hdr_bytes = HDR_RESET;
      chunk_cap = LIMIT_RESET;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, address", out_data.granted_address, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_data.granted_address !== want.granted_address)
            report_mismatch("granted_address", out_data.granted_address,
                            want.granted_address);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == CMD_FREE) expected_q.push_back(predict_free(in_data.user_address));
        else expected_q.push_back(predict_alloc(in_data.request_bytes));
      end
      if (cfg_we) begin
        if (cfg_index == CFG_HEADER) hdr_bytes = cfg_wdata;
        else if (cfg_index == CFG_LIMIT) chunk_cap = cfg_wdata[4:0];
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the buddy allocator: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module tb_top;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT = 30_000_000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_req_t in_data;
  out_res_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;
  int fails, pending;
  int cycles;
  bit calm;
  logic [14:0] live_addrs[$];
  cmd_t sent_cmds[$];
  int status_seen[4];
  int items_sent;

  buddy_block_allocator uut (.*);

  bba_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 17);

  // track granted addresses so most frees hit live blocks
  always @(posedge clk) begin
    cmd_t c;
    if (rst_n) begin
      if (out_valid && !out_stall && sent_cmds.size() > 0) begin
        c = sent_cmds.pop_front();
        status_seen[out_data.status]++;
        if (c == CMD_ALLOC && out_data.status == ST_OK) live_addrs.push_back(out_data.granted_address);
      end
      if (in_valid && !in_stall) sent_cmds.push_back(cmd_t'(in_data.command));
    end
  end

  task automatic send(cmd_t cmd, int bytes, int addr);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.command <= cmd;
    in_data.request_bytes <= 12'(bytes);
    in_data.user_address <= 15'(addr);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 7'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_live();
    int k;
    k = $urandom_range(live_addrs.size() - 1);
    send(CMD_FREE, $urandom_range(4095), live_addrs[k]);
    live_addrs.delete(k);
  endtask

  task automatic directed(int hdr);
    send(CMD_ALLOC, 0, 32767);
    send(CMD_ALLOC, 4095, 0);
    send(CMD_ALLOC, 2049 - hdr, 0);
    send(CMD_ALLOC, 2048 - hdr, 0);
    send(CMD_ALLOC, 1, 0);
    send(CMD_ALLOC, 16, 0);
    send(CMD_ALLOC, 1024, 0);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, hdr + 1);
    send(CMD_FREE, 4095, 32767);
    send(CMD_FREE, 0, 30000);
    drain();
    while (live_addrs.size() > 0) free_live();
    send(CMD_FREE, 0, hdr);
    send(CMD_ALLOC, 2, 32767);
  endtask

  task automatic random_phase(int count);
    int r, sz;
    for (int n = 0; n < count; n++) begin
      calm = (items_sent >= 500 && items_sent < 700);
      r = $urandom_range(99);
      if (r < 8) begin
        send(CMD_FREE, $urandom_range(4095), $urandom_range(32767));
      end else if (r < 12) begin
        send(CMD_ALLOC, $urandom_range(4095), $urandom_range(32767));
      end else if (live_addrs.size() > 0 && (r < 45 || live_addrs.size() > 40)) begin
        if (r == 44) send(CMD_FREE, 0, live_addrs[0]);  // may be a double free
        else free_live();
      end else begin
        r = $urandom_range(99);
        sz = (r < 70) ? $urandom_range(100, 1) :
             (r < 92) ? $urandom_range(600, 101) : $urandom_range(2048, 601);
        send(CMD_ALLOC, sz, $urandom_range(32767));
      end
    end
    drain();
  endtask

  initial begin
    int hdrs[6] = '{16, 0, 64, 33, 63, 5};
    int lims[6] = '{16, 1, 16, 3, 15, 2};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_HEADER;
    cfg_wdata = '0;
    calm = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        while (live_addrs.size() > 0) free_live();
        drain();
        repeat (20) @(posedge clk);
        cfg_write(CFG_HEADER, hdrs[p]);
        cfg_write(CFG_LIMIT, lims[p]);
      end
      directed(hdrs[p]);
      random_phase(190);
    end
    drain();
    repeat (200) @(posedge clk);
    $display("tb: %0d requests over 6 header/chunk-limit settings", items_sent);
    $display("tb: ok %0d, out of memory %0d, bad size %0d, bad free %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
